// ===== hw/rtl/cshp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cshp_pkg
// types, character codes and small helper functions shared by the cookie
// header session parser
// ----------------------------------------------------------------------------
package cshp_pkg;

	localparam int MAX_HEADER_BYTES_DEF = 4096;
	localparam int LEN_CAP_MAX          = 4095;

	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [3:0] NAME_LEN = 4'd9;

	typedef enum logic [1:0] {
		VERDICT_SESSION = 2'd0,
		VERDICT_DELETE  = 2'd1,
		VERDICT_ABORT   = 2'd2,
		VERDICT_END     = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       final_byte;
	} item_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [7:0]  pair_number;
		logic [11:0] name_offset;
		logic [11:0] name_length;
		logic [63:0] session_id;
		logic        session_valid;
		logic        header_done;
	} result_t;

	// space and 0x09..0x0d
	function automatic logic is_ws(input logic [7:0] c);
		return (c inside {8'h20, [8'h09:8'h0D]});
	endfunction

	// {is hex digit, digit value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// characters of the session cookie name
	function automatic logic [7:0] name_char(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0: r = 8'h73; // s
			4'd1: r = 8'h65; // e
			4'd2: r = 8'h73; // s
			4'd3: r = 8'h73; // s
			4'd4: r = 8'h69; // i
			4'd5: r = 8'h6F; // o
			4'd6: r = 8'h6E; // n
			4'd7: r = 8'h49; // I
			4'd8: r = 8'h64; // d
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cookie_header_session_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cookie_header_session_parser_unit
// streaming parser for Cookie header values that keeps a session id
// ----------------------------------------------------------------------------
// Takes one header byte per item on the slave side, tlast on the final byte
// of each header string, and gives at most one result item per byte: a
// session id accepted, a cookie name to delete (offset and length), a header
// abort, or a bare end-of-header on the final byte. Bytes that neither end a
// pair nor abort or end the header give no result. Rate is one item per
// cycle while the result register is free: each byte passes an input
// register and then one step of parser logic that updates the state and
// loads the result register. The input side only stalls while the result
// register holds an item that the master side has not taken. The kept
// session id persists across headers until reset; offsets and lengths
// saturate at the smaller of MAX_HEADER_BYTES - 1 and 4095.
// ----------------------------------------------------------------------------
module cookie_header_session_parser_unit #(
	parameter int MAX_HEADER_BYTES = cshp_pkg::MAX_HEADER_BYTES_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	// header byte items
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [7:0]   s_tdata,   // [7:0] char_byte
	input  wire          s_tlast,   // final_byte
	// result items
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [103:0] m_tdata,   // [7:0] pair_number, [19:8] name_offset,
	                                // [31:20] name_length, [95:32] session_id,
	                                // [96] session_valid, [103:97] zero
	output logic [1:0]   m_tuser,   // [1:0] verdict
	output logic         m_tlast    // header_done
);
	import cshp_pkg::*;

	// input register stage
	logic    valid_s1;
	item_t   item_s1;
	logic    out_free;
	logic    adv;
	logic    accept;

	result_t res;
	logic    res_valid;
	result_t res_q;

	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;
	// the held byte steps the parser whenever the result register can take a result
	assign adv      = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.char_byte  <= s_tdata;
			item_s1.final_byte <= s_tlast;
		end
	end

	// parser state and per-byte logic
	cshp_core #(
		.MAX_HEADER_BYTES(MAX_HEADER_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.item     (item_s1),
		.res      (res),
		.res_valid(res_valid)
	);

	// result register
	cshp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res_valid(res_valid),
		.res      (res),
		.ready    (m_tready),
		.valid    (m_tvalid),
		.res_q    (res_q),
		.free     (out_free)
	);

	assign m_tdata = {7'd0, res_q.session_valid, res_q.session_id, res_q.name_length,
		res_q.name_offset, res_q.pair_number};
	assign m_tuser = res_q.verdict;
	assign m_tlast = res_q.header_done;

endmodule
`default_nettype wire

// ===== hw/rtl/cshp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cshp_core
// parser state registers and the per-item next-state and result logic
// ----------------------------------------------------------------------------
module cshp_core #(
	parameter int MAX_HEADER_BYTES = cshp_pkg::MAX_HEADER_BYTES_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               step,
	input  cshp_pkg::item_t   item,
	output cshp_pkg::result_t res,
	output logic              res_valid
);
	import cshp_pkg::*;

	localparam int LEN_CAP = (MAX_HEADER_BYTES - 1 > LEN_CAP_MAX) ?
		LEN_CAP_MAX : MAX_HEADER_BYTES - 1;
	localparam int LEN_W = $clog2(LEN_CAP + 1);
	localparam logic [LEN_W-1:0] CAP = LEN_W'(LEN_CAP);

	typedef enum logic [3:0] {
		PH_SKIP  = 4'b0001,
		PH_NAME  = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_ABORT = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_PAIR  = 2'd1,
		ACT_ABORT = 2'd2
	} act_t;

	function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
		return (v >= CAP) ? CAP : v + 1'b1;
	endfunction

	phase_t           phase_q, phase_n;
	logic [3:0]       match_q, match_n;
	logic             mis_q, mis_n;
	logic [63:0]      acc_q, acc_n;
	logic             all_hex_q, all_hex_n;
	logic [LEN_W-1:0] vlen_q, vlen_n;
	logic             pend_q, pend_n;
	logic [LEN_W-1:0] offset_q, offset_n;
	logic [LEN_W-1:0] start_q, start_n;
	logic [LEN_W-1:0] nlen_q, nlen_n;
	logic [7:0]       cnt_q, cnt_n;
	logic [63:0]      sid_q, sid_n;
	logic             sv_q, sv_n;

	logic [7:0] c;
	logic       fin;
	logic       ws;
	logic [4:0] hx;
	logic       ok;
	act_t       act;
	logic [3:0]       nb_match;
	logic [LEN_W-1:0] nb_len;
	logic             nb_mis;

	assign c   = item.char_byte;
	assign fin = item.final_byte;
	assign ws  = is_ws(c);
	assign hx  = hex_val(c);

	always_comb begin
		phase_n   = phase_q;
		match_n   = match_q;
		mis_n     = mis_q;
		acc_n     = acc_q;
		all_hex_n = all_hex_q;
		vlen_n    = vlen_q;
		pend_n    = pend_q;
		offset_n  = offset_q;
		start_n   = start_q;
		nlen_n    = nlen_q;
		cnt_n     = cnt_q;
		sid_n     = sid_q;
		sv_n      = sv_q;
		act       = ACT_NONE;
		ok        = 1'b0;

		// name byte base: a fresh name in the skip phase, the running one otherwise
		if (phase_q == PH_SKIP) begin
			nb_match = 4'd0;
			nb_len   = '0;
			nb_mis   = 1'b0;
		end else begin
			nb_match = match_q;
			nb_len   = nlen_q;
			nb_mis   = mis_q;
		end

		case (phase_q)
			PH_SKIP: begin
				if (!ws) begin
					start_n = offset_q;
					nlen_n  = '0;
					match_n = 4'd0;
					mis_n   = 1'b0;
					if (c == CH_SEMI) begin
						act = ACT_ABORT;
					end else if (c == CH_EQ) begin
						mis_n     = 1'b1;
						acc_n     = '0;
						all_hex_n = 1'b1;
						vlen_n    = '0;
						pend_n    = 1'b0;
						phase_n   = PH_VALUE;
						if (fin) act = ACT_ABORT;
					end else begin
						nlen_n = sat_inc(nb_len);
						if (nb_mis || nb_match >= NAME_LEN) begin
							mis_n = 1'b1;
						end else begin
							mis_n   = (c != name_char(nb_match));
							match_n = nb_match + 4'd1;
						end
						phase_n = PH_NAME;
						if (fin) act = ACT_ABORT;
					end
				end
			end
			PH_NAME: begin
				if (c == CH_SEMI) begin
					act = ACT_ABORT;
				end else if (c == CH_EQ) begin
					acc_n     = '0;
					all_hex_n = 1'b1;
					vlen_n    = '0;
					pend_n    = 1'b0;
					phase_n   = PH_VALUE;
					if (fin) act = ACT_ABORT;
				end else begin
					nlen_n = sat_inc(nb_len);
					if (nb_mis || nb_match >= NAME_LEN) begin
						mis_n = 1'b1;
					end else begin
						mis_n   = (c != name_char(nb_match));
						match_n = nb_match + 4'd1;
					end
					if (fin) act = ACT_ABORT;
				end
			end
			PH_VALUE: begin
				if (ws) begin
					if (fin) act = (vlen_q != '0) ? ACT_PAIR : ACT_ABORT;
					else pend_n = 1'b1;
				end else begin
					// whitespace held back inside a value counts once, and is not hex
					if (pend_q) begin
						all_hex_n = 1'b0;
						vlen_n    = sat_inc(vlen_q);
						pend_n    = 1'b0;
					end
					if (c == CH_SEMI) begin
						act     = ACT_PAIR;
						phase_n = PH_SKIP;
					end else begin
						if (!hx[4]) begin
							all_hex_n = 1'b0;
						end else if (acc_q[63:60] != 4'd0) begin
							acc_n = '1;
						end else begin
							acc_n = {acc_q[59:0], hx[3:0]};
						end
						vlen_n = sat_inc(vlen_n);
						if (fin) act = ACT_PAIR;
					end
				end
			end
			PH_ABORT: begin
			end
			default: begin
			end
		endcase

		ok = !mis_n && (match_n == NAME_LEN) && all_hex_n && (vlen_n != '0)
			&& (acc_n != 64'd0);

		res.pair_number = cnt_q;
		res.header_done = fin;
		res.name_offset = 12'd0;
		res.name_length = 12'd0;
		res.verdict     = VERDICT_END;
		res_valid       = fin;

		case (act)
			ACT_PAIR: begin
				if (ok) begin
					sid_n = acc_n;
					sv_n  = 1'b1;
				end
				res.verdict     = ok ? VERDICT_SESSION : VERDICT_DELETE;
				res.name_offset = 12'(start_n);
				res.name_length = 12'(nlen_n);
				res_valid       = 1'b1;
				if (cnt_q != 8'hFF) cnt_n = cnt_q + 8'd1;
			end
			ACT_ABORT: begin
				res.verdict = VERDICT_ABORT;
				res_valid   = 1'b1;
				phase_n     = PH_ABORT;
			end
			default: begin
			end
		endcase

		res.session_id    = sid_n;
		res.session_valid = sv_n;

		if (fin) begin
			phase_n   = PH_SKIP;
			match_n   = 4'd0;
			mis_n     = 1'b0;
			acc_n     = '0;
			all_hex_n = 1'b1;
			vlen_n    = '0;
			pend_n    = 1'b0;
			offset_n  = '0;
			start_n   = '0;
			nlen_n    = '0;
			cnt_n     = 8'd0;
		end else begin
			offset_n = sat_inc(offset_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SKIP;
			match_q   <= 4'd0;
			mis_q     <= 1'b0;
			acc_q     <= '0;
			all_hex_q <= 1'b1;
			vlen_q    <= '0;
			pend_q    <= 1'b0;
			offset_q  <= '0;
			start_q   <= '0;
			nlen_q    <= '0;
			cnt_q     <= 8'd0;
			sid_q     <= '0;
			sv_q      <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			match_q   <= match_n;
			mis_q     <= mis_n;
			acc_q     <= acc_n;
			all_hex_q <= all_hex_n;
			vlen_q    <= vlen_n;
			pend_q    <= pend_n;
			offset_q  <= offset_n;
			start_q   <= start_n;
			nlen_q    <= nlen_n;
			cnt_q     <= cnt_n;
			sid_q     <= sid_n;
			sv_q      <= sv_n;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cshp_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cshp_out_reg
// result register on the master side of the parser
// ----------------------------------------------------------------------------
module cshp_out_reg (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               load,
	input  wire               res_valid,
	input  cshp_pkg::result_t res,
	input  wire               ready,
	output logic              valid,
	output cshp_pkg::result_t res_q,
	output logic              free
);
	import cshp_pkg::*;

	logic valid_q;

	assign valid = valid_q;
	assign free  = !valid_q || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res_valid;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire
